>>> rtl/kts_pkg.sv
package kts_pkg;

	// generator and table geometry
	localparam int RING_LEN  = 32;
	localparam int LAG_WRITE = 31;
	localparam int LAG_TAP   = 19;
	localparam int ROW_LEN   = 256;
	localparam int BYTE_W    = 8;
	localparam int ADDR_W    = 2 * BYTE_W;

	localparam logic [BYTE_W-1:0] SEED [RING_LEN] = '{
		8'd29, 8'd87, 8'd191, 8'd237, 8'd200, 8'd8, 8'd74, 8'd82,
		8'd196, 8'd183, 8'd78, 8'd79, 8'd41, 8'd122, 8'd173, 8'd109,
		8'd240, 8'd34, 8'd63, 8'd108, 8'd180, 8'd173, 8'd156, 8'd176,
		8'd53, 8'd30, 8'd37, 8'd8, 8'd49, 8'd240, 8'd159, 8'd255
	};

	// function codes of a request
	typedef enum logic [1:0] {
		FN_SETUP = 2'd0,
		FN_ENC   = 2'd1,
		FN_DEC   = 2'd2
	} func_t;

	typedef struct packed {
		logic [1:0]        func;
		logic [BYTE_W-1:0] in_byte;
	} req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              not_ready;
	} rsp_t;

	// keystream generator control
	typedef struct packed {
		logic reload;
		logic draw;
	} gen_ctl_t;

	// table memory accesses
	typedef struct packed {
		logic              fwd_we;
		logic [ADDR_W-1:0] fwd_waddr;
		logic [BYTE_W-1:0] fwd_wdata;
		logic              fwd_re;
		logic [ADDR_W-1:0] fwd_raddr_a;
		logic [ADDR_W-1:0] fwd_raddr_b;
		logic              inv_we;
		logic [ADDR_W-1:0] inv_waddr;
		logic [BYTE_W-1:0] inv_wdata;
		logic              inv_re;
		logic [ADDR_W-1:0] inv_raddr;
	} tbl_req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] fwd_rdata_a;
		logic [BYTE_W-1:0] fwd_rdata_b;
		logic [BYTE_W-1:0] inv_rdata;
	} tbl_rsp_t;

endpackage

>>> rtl/kts_keygen.sv
module kts_keygen import kts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  gen_ctl_t          ctl,
	output logic [BYTE_W-1:0] key
);

	// sr[j] holds ring entry (index + 1 + j), so both taps sit at fixed places
	logic [BYTE_W-1:0] sr_q [RING_LEN];

	// next keystream byte: lagged sum of the two taps
	assign key = sr_q[0] + sr_q[LAG_TAP];

	// rotate by one per draw, the new byte lands at the write lag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < RING_LEN; j++) begin
				sr_q[j] <= SEED[(j + 1) % RING_LEN];
			end
		end else if (ctl.reload) begin
			for (int j = 0; j < RING_LEN; j++) begin
				sr_q[j] <= SEED[(j + 1) % RING_LEN];
			end
		end else if (ctl.draw) begin
			for (int j = 0; j < RING_LEN; j++) begin
				if (j == LAG_WRITE - 1) begin
					sr_q[j] <= key;
				end else begin
					sr_q[j] <= sr_q[(j + 1) % RING_LEN];
				end
			end
		end
	end

endmodule

>>> rtl/kts_tables.sv
module kts_tables import kts_pkg::*; (
	input  logic     clk,
	input  tbl_req_t req,
	output tbl_rsp_t rsp
);

	localparam int DEPTH = ROW_LEN * ROW_LEN;

	logic [BYTE_W-1:0] fwd_mem [DEPTH];
	logic [BYTE_W-1:0] inv_mem [DEPTH];

	// forward table: one write port, two registered read ports
	// inverse table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (req.fwd_we) begin
			fwd_mem[req.fwd_waddr] <= req.fwd_wdata;
		end
		if (req.fwd_re) begin
			rsp.fwd_rdata_a <= fwd_mem[req.fwd_raddr_a];
			rsp.fwd_rdata_b <= fwd_mem[req.fwd_raddr_b];
		end
		if (req.inv_we) begin
			inv_mem[req.inv_waddr] <= req.inv_wdata;
		end
		if (req.inv_re) begin
			rsp.inv_rdata <= inv_mem[req.inv_raddr];
		end
	end

endmodule

>>> rtl/keyed_table_substitution_cipher.sv
// Byte substitution cipher driven by a 32-byte lagged additive keystream. A setup
// transaction reloads the seed and rebuilds 256 shuffled permutation rows with their
// inverses; each row takes an identity fill, a swap per entry (read both entries,
// write each back) and a pass to build the inverse row. Encipher and decipher
// transactions make one keystream draw and one table read with a registered read
// port. Cipher requests before any setup, and unused function codes, answer in the
// cycle after acceptance. One transaction is worked on at a time; the response
// register lets a new request in while the last result is being taken.
module keyed_table_substitution_cipher import kts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam logic [BYTE_W-1:0] LAST = BYTE_W'(ROW_LEN - 1);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_FILL     = 8'b0000_0010,
		S_SW_RD    = 8'b0000_0100,
		S_SW_WA    = 8'b0000_1000,
		S_SW_WB    = 8'b0001_0000,
		S_INV_RD   = 8'b0010_0000,
		S_INV_LAST = 8'b0100_0000,
		S_CIPH     = 8'b1000_0000
	} state_t;

	state_t            state_q;
	logic [BYTE_W-1:0] row_q;
	logic [BYTE_W-1:0] ent_q;
	logic [BYTE_W-1:0] z_q;
	logic [1:0]        func_q;
	logic              tables_ready_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;
	logic              pend_s1;
	logic [BYTE_W-1:0] ent_s1;

	logic              req_fire;
	logic              out_free;
	logic              rsp_load;
	rsp_t              rsp_nxt;
	logic [BYTE_W-1:0] key;
	gen_ctl_t          gen_ctl;
	tbl_req_t          tbl_req;
	tbl_rsp_t          tbl_rsp;

	kts_keygen u_keygen (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (gen_ctl),
		.key    (key)
	);

	kts_tables u_tables (
		.clk (clk),
		.req (tbl_req),
		.rsp (tbl_rsp)
	);

	// handshake
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE) || !out_free;
	assign req_fire  = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// memory and generator accesses per state
	always_comb begin
		tbl_req = '0;
		gen_ctl = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					if (req.func == FN_SETUP) begin
						gen_ctl.reload = 1'b1;
					end else if ((req.func == FN_ENC || req.func == FN_DEC) &&
							tables_ready_q) begin
						gen_ctl.draw        = 1'b1;
						tbl_req.fwd_re      = (req.func == FN_ENC);
						tbl_req.inv_re      = (req.func == FN_DEC);
						tbl_req.fwd_raddr_a = {key, req.in_byte};
						tbl_req.inv_raddr   = {key, req.in_byte};
					end
				end
			end
			S_FILL: begin
				tbl_req.fwd_we    = 1'b1;
				tbl_req.fwd_waddr = {row_q, ent_q};
				tbl_req.fwd_wdata = ent_q;
			end
			S_SW_RD: begin
				gen_ctl.draw        = 1'b1;
				tbl_req.fwd_re      = 1'b1;
				tbl_req.fwd_raddr_a = {row_q, ent_q};
				tbl_req.fwd_raddr_b = {row_q, key};
			end
			S_SW_WA: begin
				tbl_req.fwd_we    = 1'b1;
				tbl_req.fwd_waddr = {row_q, ent_q};
				tbl_req.fwd_wdata = tbl_rsp.fwd_rdata_b;
			end
			S_SW_WB: begin
				tbl_req.fwd_we    = 1'b1;
				tbl_req.fwd_waddr = {row_q, z_q};
				tbl_req.fwd_wdata = tbl_rsp.fwd_rdata_a;
			end
			S_INV_RD: begin
				tbl_req.fwd_re      = 1'b1;
				tbl_req.fwd_raddr_a = {row_q, ent_q};
				tbl_req.inv_we      = pend_s1;
				tbl_req.inv_waddr   = {row_q, tbl_rsp.fwd_rdata_a};
				tbl_req.inv_wdata   = ent_s1;
			end
			S_INV_LAST: begin
				tbl_req.inv_we    = 1'b1;
				tbl_req.inv_waddr = {row_q, tbl_rsp.fwd_rdata_a};
				tbl_req.inv_wdata = ent_s1;
			end
			S_CIPH: begin
				tbl_req = '0;
			end
			default: begin
				tbl_req = '0;
			end
		endcase
	end

	// response register load
	always_comb begin
		rsp_load = 1'b0;
		rsp_nxt  = '0;
		if (state_q == S_IDLE && req_fire && req.func != FN_SETUP) begin
			if (req.func == FN_ENC || req.func == FN_DEC) begin
				rsp_load          = !tables_ready_q;
				rsp_nxt.not_ready = 1'b1;
			end else begin
				rsp_load = 1'b1;
			end
		end else if (state_q == S_CIPH) begin
			rsp_load         = 1'b1;
			rsp_nxt.out_byte = (func_q == FN_ENC) ? tbl_rsp.fwd_rdata_a : tbl_rsp.inv_rdata;
		end else if (state_q == S_INV_LAST && row_q == LAST && out_free) begin
			rsp_load = 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			row_q          <= '0;
			ent_q          <= '0;
			tables_ready_q <= 1'b0;
			rsp_valid_q    <= 1'b0;
			pend_s1        <= 1'b0;
		end else begin
			rsp_valid_q <= rsp_load || (rsp_valid_q && rsp_stall);
			pend_s1     <= (state_q == S_INV_RD);
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						if (req.func == FN_SETUP) begin
							row_q   <= '0;
							ent_q   <= '0;
							state_q <= S_FILL;
						end else if ((req.func == FN_ENC || req.func == FN_DEC) &&
								tables_ready_q) begin
							state_q <= S_CIPH;
						end
					end
				end
				S_FILL: begin
					ent_q <= ent_q + 1'b1;
					if (ent_q == LAST) begin
						state_q <= S_SW_RD;
					end
				end
				S_SW_RD: begin
					state_q <= S_SW_WA;
				end
				S_SW_WA: begin
					state_q <= S_SW_WB;
				end
				S_SW_WB: begin
					ent_q   <= ent_q + 1'b1;
					state_q <= (ent_q == LAST) ? S_INV_RD : S_SW_RD;
				end
				S_INV_RD: begin
					ent_q <= ent_q + 1'b1;
					if (ent_q == LAST) begin
						state_q <= S_INV_LAST;
					end
				end
				S_INV_LAST: begin
					if (row_q != LAST) begin
						row_q   <= row_q + 1'b1;
						state_q <= S_FILL;
					end else if (out_free) begin
						tables_ready_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				S_CIPH: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_nxt;
		end
		if (state_q == S_SW_RD) begin
			z_q <= key;
		end
		if (state_q == S_INV_RD) begin
			ent_s1 <= ent_q;
		end
		if (req_fire) begin
			func_q <= req.func;
		end
	end

	// a ready cipher transaction moves to S_CIPH, then its response becomes valid
	a_ciph_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && tables_ready_q && (req.func == FN_ENC || req.func == FN_DEC))
		|=> (state_q == S_CIPH) ##1 rsp_valid_q)
		else $error("cipher transaction did not answer in two cycles");

	// tables stay ready once built
	a_ready_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(tables_ready_q))
		else $error("tables ready flag dropped");

	// tables are only written while a setup is running
	a_write_in_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(tbl_req.fwd_we || tbl_req.inv_we) |-> (state_q != S_IDLE && state_q != S_CIPH))
		else $error("table write outside setup");

	// a not-ready answer only exists while the tables are unbuilt
	a_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.not_ready) |-> !tables_ready_q)
		else $error("not-ready response with tables built");

endmodule
